### rtl/bbsc_pkg.sv
package bbsc_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int Q14_ONE    = 16384;
  localparam int Q14_HALF   = 8192;

  // quarter-wave sine polynomial coefficients, Q16
  localparam int SIN_P = 205887;
  localparam int SIN_Q = 84093;
  localparam int SIN_R = 9279;

  localparam int DOT_W  = 31;  // u.e, Q3.28
  localparam int ADOT_W = 16;  // |u.e| rounded to Q14
  localparam int PROD_W = 47;  // half extent times |u.e|
  localparam int RAD_W  = 48;  // projected radius, scale 2^14
  localparam int DS_W   = 49;  // signed projected center distance
  localparam int DIST_W = 48;
  localparam int PEN_W  = 51;  // signed overlap

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic signed [31:0] a_center_x;
    logic signed [31:0] a_center_y;
    logic [30:0]        a_half_x;
    logic [30:0]        a_half_y;
    logic [15:0]        a_angle;
    logic signed [31:0] b_center_x;
    logic signed [31:0] b_center_y;
    logic [30:0]        b_half_x;
    logic [30:0]        b_half_y;
    logic [15:0]        b_angle;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [31:0]        penetration;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic [1:0]         axis_index;
  } result_t;

  typedef struct packed {
    q14_t c;
    q14_t s;
  } basis_t;

  typedef struct packed {
    q14_t ax;
    q14_t ay;
  } vec_t;

  typedef struct packed {
    vec_t [3:0]         axis;
    logic signed [31:0] acx;
    logic signed [31:0] acy;
    logic signed [31:0] bcx;
    logic signed [31:0] bcy;
  } geo_t;

  typedef struct packed {
    logic signed [PEN_W-1:0] pen;
    logic [RAD_W-1:0]        ra;
    logic [RAD_W-1:0]        rb;
    logic                    pos;
  } cand_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
    cand_t      best;
  } pick_t;

endpackage

### rtl/bbsc_sincos.sv
module bbsc_sincos (
  input  logic            clk,
  input  logic            en,
  input  logic [15:0]     angle,
  output bbsc_pkg::basis_t basis
);
  import bbsc_pkg::*;

  typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quad_t;

  function automatic logic [16:0] phase(input logic [15:0] a);
    logic [63:0] p;
    p = 64'(a[ANGLE_BITS-3:0]);
    return 17'((p << 8) >> (ANGLE_BITS - 10));
  endfunction

  function automatic logic [16:0] sq(input logic [16:0] x);
    logic [33:0] p;
    p = 34'(x) * 34'(x);
    return p[32:16];
  endfunction

  function automatic logic [16:0] poly1(input logic [16:0] x2);
    logic [33:0] p;
    p = 34'(SIN_R) * 34'(x2);
    return 17'(SIN_Q) - 17'(p >> 16);
  endfunction

  function automatic logic [17:0] poly2(input logic [16:0] t1, input logic [16:0] x2);
    logic [33:0] p;
    p = 34'(t1) * 34'(x2);
    return 18'(SIN_P) - 18'(p >> 16);
  endfunction

  function automatic q14_t fin(input logic [16:0] x, input logic [17:0] t2);
    logic [34:0] p;
    logic [17:0] t;
    logic [15:0] r;
    p = 35'(x) * 35'(t2);
    t = 18'(p >> 17);
    r = 16'((t + 18'd2) >> 2);
    if (r > 16'(Q14_ONE)) r = 16'(Q14_ONE);
    return $signed(r);
  endfunction

  logic [1:0]  q1, q2, q3;
  logic [16:0] xs1, xc1, xs2, xc2, xs3, xc3;
  logic [16:0] x2s1, x2c1, x2s2, x2c2;
  logic [16:0] t1s2, t1c2;
  logic [17:0] t2s3, t2c3;
  logic [16:0] x_in, xc_in;
  q14_t        sv, cv;

  assign x_in  = phase(angle);
  assign xc_in = 17'(65536) - x_in;

  always_ff @(posedge clk) begin
    if (en) begin
      q1   <= angle[ANGLE_BITS-1 -: 2];
      xs1  <= x_in;
      xc1  <= xc_in;
      x2s1 <= sq(x_in);
      x2c1 <= sq(xc_in);

      q2   <= q1;
      xs2  <= xs1;
      xc2  <= xc1;
      x2s2 <= x2s1;
      x2c2 <= x2c1;
      t1s2 <= poly1(x2s1);
      t1c2 <= poly1(x2c1);

      q3   <= q2;
      xs3  <= xs2;
      xc3  <= xc2;
      t2s3 <= poly2(t1s2, x2s2);
      t2c3 <= poly2(t1c2, x2c2);

      unique case (quad_t'(q3))
        Q_FIRST:  basis <= '{c: cv,  s: sv};
        Q_SECOND: basis <= '{c: -sv, s: cv};
        Q_THIRD:  basis <= '{c: -cv, s: -sv};
        Q_FOURTH: basis <= '{c: sv,  s: -cv};
        default:  basis <= '{c: cv,  s: sv};
      endcase
    end
  end

  assign sv = fin(xs3, t2s3);
  assign cv = fin(xc3, t2c3);

endmodule

### rtl/bbsc_proj.sv
module bbsc_proj (
  input  logic                    clk,
  input  logic                    en,
  input  bbsc_pkg::basis_t        ba,
  input  bbsc_pkg::basis_t        bb,
  input  bbsc_pkg::item_t         item,
  output bbsc_pkg::cand_t [3:0]   cand,
  output bbsc_pkg::geo_t          geo
);
  import bbsc_pkg::*;

  function automatic logic signed [DOT_W-1:0] dot(input vec_t a, input vec_t b);
    logic signed [31:0] p;
    p = $signed(a.ax) * $signed(b.ax) + $signed(a.ay) * $signed(b.ay);
    return DOT_W'(p);
  endfunction

  function automatic logic signed [DS_W-1:0] dproj(input logic signed [32:0] dx,
                                                  input logic signed [32:0] dy,
                                                  input vec_t u);
    logic signed [DS_W-1:0] p;
    p = dx * $signed(u.ax) + dy * $signed(u.ay);
    return p;
  endfunction

  function automatic logic [ADOT_W-1:0] rnd_abs(input logic signed [DOT_W-1:0] d);
    logic [DOT_W-1:0] m;
    m = d[DOT_W-1] ? DOT_W'(-d) : DOT_W'(d);
    return ADOT_W'((m + DOT_W'(Q14_HALF)) >> 14);
  endfunction

  vec_t [3:0]         axis;
  logic signed [32:0] dx, dy;

  logic signed [DOT_W-1:0] dot5 [4][4];
  logic signed [DS_W-1:0]  ds5 [4];
  logic [30:0]             h5 [4];
  geo_t                    geo5, geo6;

  logic [PROD_W-1:0] prod6 [4][4];
  logic [DIST_W-1:0] dist6 [4];
  logic              pos6 [4];

  assign axis[0] = '{ax: ba.c,  ay: ba.s};
  assign axis[1] = '{ax: -ba.s, ay: ba.c};
  assign axis[2] = '{ax: bb.c,  ay: bb.s};
  assign axis[3] = '{ax: -bb.s, ay: bb.c};

  assign dx = 33'(item.b_center_x) - 33'(item.a_center_x);
  assign dy = 33'(item.b_center_y) - 33'(item.a_center_y);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          dot5[i][j] <= dot(axis[i], axis[j]);
        end
        ds5[i] <= dproj(dx, dy, axis[i]);
      end
      h5[0] <= item.a_half_x;
      h5[1] <= item.a_half_y;
      h5[2] <= item.b_half_x;
      h5[3] <= item.b_half_y;
      geo5  <= '{axis: axis, acx: item.a_center_x, acy: item.a_center_y,
                 bcx: item.b_center_x, bcy: item.b_center_y};

      // local axes of A pair with A's half extents, B's with B's
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          prod6[i][k] <= PROD_W'(h5[k]) * PROD_W'(rnd_abs(dot5[i][k]));
        end
        dist6[i] <= ds5[i][DS_W-1] ? DIST_W'(-ds5[i]) : DIST_W'(ds5[i]);
        pos6[i]  <= !ds5[i][DS_W-1];
      end
      geo6 <= geo5;

      for (int i = 0; i < 4; i++) begin
        cand[i].ra  <= RAD_W'(prod6[i][0]) + RAD_W'(prod6[i][1]);
        cand[i].rb  <= RAD_W'(prod6[i][2]) + RAD_W'(prod6[i][3]);
        cand[i].pen <= PEN_W'(prod6[i][0]) + PEN_W'(prod6[i][1]) + PEN_W'(prod6[i][2])
                       + PEN_W'(prod6[i][3]) - PEN_W'(dist6[i]);
        cand[i].pos <= pos6[i];
      end
      geo <= geo6;
    end
  end

endmodule

### rtl/bbsc_select.sv
module bbsc_select (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           eps,
  input  bbsc_pkg::cand_t [3:0] cand,
  input  bbsc_pkg::geo_t        gi,
  output bbsc_pkg::pick_t       pick,
  output bbsc_pkg::geo_t        go
);
  import bbsc_pkg::*;

  // later axis wins only when smaller by more than the tie margin
  function automatic logic better(input logic signed [PEN_W-1:0] pen,
                                  input logic signed [PEN_W-1:0] best,
                                  input logic [15:0] e);
    logic signed [PEN_W:0] lim;
    lim = $signed((PEN_W+1)'(best)) - $signed((PEN_W+1)'({e, 14'd0}));
    return $signed((PEN_W+1)'(pen)) < lim;
  endfunction

  pick_t pick8, p9a, p9b;
  cand_t c2_8, c3_8;
  geo_t  geo8;

  always_comb begin
    p9a = pick8;
    if (better(c2_8.pen, pick8.best.pen, eps)) begin
      p9a.best = c2_8;
      p9a.idx  = 2'd2;
    end
    p9b = p9a;
    if (better(c3_8.pen, p9a.best.pen, eps)) begin
      p9b.best = c3_8;
      p9b.idx  = 2'd3;
    end
    p9b.hit = pick8.hit && (c2_8.pen > 0) && (c3_8.pen > 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pick8.hit <= (cand[0].pen > 0) && (cand[1].pen > 0);
      if (better(cand[1].pen, cand[0].pen, eps)) begin
        pick8.best <= cand[1];
        pick8.idx  <= 2'd1;
      end else begin
        pick8.best <= cand[0];
        pick8.idx  <= 2'd0;
      end
      c2_8 <= cand[2];
      c3_8 <= cand[3];
      geo8 <= gi;

      pick <= p9b;
      go   <= geo8;
    end
  end

endmodule

### rtl/bbsc_contact.sv
module bbsc_contact (
  input  logic              clk,
  input  logic              en,
  input  bbsc_pkg::pick_t   pick,
  input  bbsc_pkg::geo_t    geo,
  output bbsc_pkg::result_t res
);
  import bbsc_pkg::*;

  function automatic logic signed [31:0] mid(input logic signed [32:0] sum,
                                             input logic signed [50:0] m);
    logic signed [52:0] v;
    logic signed [37:0] sh;
    v  = (53'(sum) <<< 14) + 53'(m) + 53'(Q14_ONE);
    sh = 38'(v >>> 15);
    if (sh > 38'sd2147483647) return 32'sh7fffffff;
    else if (sh < -38'sd2147483648) return 32'sh80000000;
    else return sh[31:0];
  endfunction

  vec_t                   u, n;
  logic [33:0]            ra16, rb16;
  logic signed [34:0]     diff;
  logic [PEN_W-1:0]       pen_r;
  logic [PEN_W-15:0]      pen_q;

  logic                   hit10;
  logic [1:0]             idx10;
  vec_t                   n10;
  logic signed [50:0]     mx10, my10;
  logic signed [32:0]     sx10, sy10;
  logic [31:0]            pen10;

  assign u    = geo.axis[pick.idx];
  assign n    = pick.best.pos ? u : '{ax: -u.ax, ay: -u.ay};
  assign ra16 = 34'((pick.best.ra + RAD_W'(Q14_HALF)) >> 14);
  assign rb16 = 34'((pick.best.rb + RAD_W'(Q14_HALF)) >> 14);
  assign diff = $signed({1'b0, ra16}) - $signed({1'b0, rb16});
  assign pen_r = PEN_W'(pick.best.pen) + PEN_W'(Q14_HALF);
  assign pen_q = pen_r[PEN_W-1:14];

  always_ff @(posedge clk) begin
    if (en) begin
      hit10 <= pick.hit;
      idx10 <= pick.idx;
      n10   <= n;
      mx10  <= diff * $signed(n.ax);
      my10  <= diff * $signed(n.ay);
      sx10  <= 33'(geo.acx) + 33'(geo.bcx);
      sy10  <= 33'(geo.acy) + 33'(geo.bcy);
      pen10 <= (|pen_q[PEN_W-15:32]) ? 32'hffffffff : pen_q[31:0];

      if (hit10) begin
        res.hit         <= 1'b1;
        res.normal_x    <= n10.ax;
        res.normal_y    <= n10.ay;
        res.penetration <= pen10;
        res.contact_x   <= mid(sx10, mx10);
        res.contact_y   <= mid(sy10, my10);
        res.axis_index  <= idx10;
      end else begin
        res <= '0;
      end
    end
  end

endmodule

### rtl/box_box_sat_contact_unit.sv
// Separating-axis contact test for two oriented boxes in the plane. One box
// pair is accepted per clock when not stalled; its result passes through
// twelve register stages: the input register, the four-multiply sine
// polynomial (4 stages), the axis projections (3 stages), the two-stage
// axis pick and the two-stage contact point math, whose second stage is
// the output register. A stall on the result side holds the whole
// pipeline, so item_stall follows result_stall while a result is waiting.
// tie_epsilon (reset 7) is written through the cfg channel, which is always
// ready, and should only change while the pipeline is empty.
module box_box_sat_contact_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bbsc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bbsc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import bbsc_pkg::*;

  localparam int DEPTH = 12;

  logic             en;
  logic [DEPTH-1:0] v;
  logic [15:0]      tie_epsilon;
  item_t            r0;
  item_t            dly [4];
  basis_t           ba, bb;
  cand_t [3:0]      cand;
  geo_t             geo7, geo9;
  pick_t            pick;

  assign cfg_ready    = 1'b1;
  assign result_valid = v[DEPTH-1];
  assign item_stall   = v[DEPTH-1] && result_stall;
  assign en           = !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tie_epsilon <= 16'd7;
    end else if (cfg_valid && cfg_ready) begin
      tie_epsilon <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0     <= item;
      dly[0] <= r0;
      dly[1] <= dly[0];
      dly[2] <= dly[1];
      dly[3] <= dly[2];
    end
  end

  bbsc_sincos u_sc_a (.clk(clk), .en(en), .angle(r0.a_angle), .basis(ba));
  bbsc_sincos u_sc_b (.clk(clk), .en(en), .angle(r0.b_angle), .basis(bb));

  bbsc_proj u_proj (
    .clk(clk), .en(en), .ba(ba), .bb(bb), .item(dly[3]), .cand(cand), .geo(geo7)
  );

  bbsc_select u_sel (
    .clk(clk), .en(en), .eps(tie_epsilon), .cand(cand), .gi(geo7), .pick(pick), .go(geo9)
  );

  bbsc_contact u_contact (.clk(clk), .en(en), .pick(pick), .geo(geo9), .res(result));

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |->
      result.penetration == 32'd0 && result.axis_index == 2'd0 &&
      result.contact_x == 32'sd0 && result.contact_y == 32'sd0)
    else $error("miss result carries nonzero fields");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |->
      result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
      result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384)
    else $error("normal out of Q2.14 unit range");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result pending");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> tie_epsilon == $past(cfg_data))
    else $error("tie epsilon transfer lost");

endmodule

### sim/tb.sv
module tb;
  import bbsc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 60;

  class contact_scoreboard;
    result_t pending[$];
    int      errors;
    logic [15:0] eps;

    function new();
      errors = 0;
      eps    = 16'd7;
    endfunction

    function automatic longint unsigned qsin(longint unsigned x);
      longint unsigned x2, t;
      x2 = (x * x) >> 16;
      t  = (longint'(SIN_R) * x2) >> 16;
      t  = SIN_Q - t;
      t  = (t * x2) >> 16;
      t  = SIN_P - t;
      t  = (x * t) >> 17;
      t  = (t + 2) >> 2;
      if (t > Q14_ONE) t = Q14_ONE;
      return t;
    endfunction

    function automatic void basis(logic [15:0] ang, output longint c, output longint s);
      logic [1:0]      quad;
      longint unsigned x;
      longint          sv, cv;
      quad = ang[15:14];
      x    = longint'(ang[13:0]) << 2;
      sv   = qsin(x);
      cv   = qsin(65536 - x);
      case (quad)
        2'd0: begin c = cv;  s = sv;  end
        2'd1: begin c = -sv; s = cv;  end
        2'd2: begin c = -cv; s = -sv; end
        default: begin c = sv; s = -cv; end
      endcase
    endfunction

    function automatic longint adot(longint ux, longint uy, longint ex, longint ey);
      longint d;
      d = ux * ex + uy * ey;
      if (d < 0) d = -d;
      return (d + Q14_HALF) >>> 14;
    endfunction

    // floor division by 2^15
    function automatic longint fshift15(longint v);
      return v >>> 15;
    endfunction

    function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic result_t predict_contact(item_t it);
      result_t r;
      longint ax[4], ay[4];
      longint c, s, acx, acy, bcx, bcy, dx, dy, e, ra, rb, ds, dabs, pen;
      longint best, bra, brb, n0, n1, ra16, rb16, sx, sy;
      longint unsigned p;
      int bi;
      bit pos;
      r    = '0;
      best = 0; bra = 0; brb = 0; bi = 0; pos = 1;
      basis(it.a_angle, c, s);
      ax[0] = c;  ay[0] = s;  ax[1] = -s; ay[1] = c;
      basis(it.b_angle, c, s);
      ax[2] = c;  ay[2] = s;  ax[3] = -s; ay[3] = c;
      acx = it.a_center_x; acy = it.a_center_y;
      bcx = it.b_center_x; bcy = it.b_center_y;
      dx = bcx - acx; dy = bcy - acy;
      e  = longint'(eps) * Q14_ONE;
      for (int i = 0; i < 4; i++) begin
        ra = longint'(it.a_half_x) * adot(ax[i], ay[i], ax[0], ay[0])
           + longint'(it.a_half_y) * adot(ax[i], ay[i], ax[1], ay[1]);
        rb = longint'(it.b_half_x) * adot(ax[i], ay[i], ax[2], ay[2])
           + longint'(it.b_half_y) * adot(ax[i], ay[i], ax[3], ay[3]);
        ds   = dx * ax[i] + dy * ay[i];
        dabs = ds < 0 ? -ds : ds;
        pen  = ra + rb - dabs;
        if (pen <= 0) return '0;
        if (i == 0 || pen < best - e) begin
          best = pen; bi = i; pos = ds >= 0; bra = ra; brb = rb;
        end
      end
      n0   = pos ? ax[bi] : -ax[bi];
      n1   = pos ? ay[bi] : -ay[bi];
      ra16 = (bra + Q14_HALF) >>> 14;
      rb16 = (brb + Q14_HALF) >>> 14;
      p    = (longint'(best) + Q14_HALF) >> 14;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      sx = (acx + bcx) * Q14_ONE + n0 * (ra16 - rb16);
      sy = (acy + bcy) * Q14_ONE + n1 * (ra16 - rb16);
      r.hit         = 1'b1;
      r.normal_x    = n0[15:0];
      r.normal_y    = n1[15:0];
      r.penetration = p[31:0];
      r.contact_x   = 32'(sat32(fshift15(sx + Q14_ONE)));
      r.contact_y   = 32'(sat32(fshift15(sy + Q14_ONE)));
      r.axis_index  = bi[1:0];
      return r;
    endfunction

    function void note_item(item_t it);
      pending = {pending, predict_contact(it)};
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit ||
          got.normal_x !== exp_r.normal_x || got.normal_y !== exp_r.normal_y ||
          got.penetration !== exp_r.penetration ||
          got.contact_x !== exp_r.contact_x || got.contact_y !== exp_r.contact_y ||
          got.axis_index !== exp_r.axis_index) begin
        $display("%0t: mismatch expected hit=%0d n=(%0d,%0d) pen=%h c=(%0d,%0d) ax=%0d",
                 $time, exp_r.hit, exp_r.normal_x, exp_r.normal_y, exp_r.penetration,
                 exp_r.contact_x, exp_r.contact_y, exp_r.axis_index);
        $display("%0t:          actual   hit=%0d n=(%0d,%0d) pen=%h c=(%0d,%0d) ax=%0d",
                 $time, got.hit, got.normal_x, got.normal_y, got.penetration,
                 got.contact_x, got.contact_y, got.axis_index);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        item_valid, item_stall;
  item_t       item;
  logic        result_valid, result_stall;
  result_t     result;
  logic        cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  contact_scoreboard sb = new();
  int  send_idle_pct, recv_stall_pct;
  int  hold_off_cycles;
  int  hold_off_req, hold_off_ack;
  int  idle_cycles;

  box_box_sat_contact_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall    <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_ack    <= 0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(result);
      if (hold_off_req != hold_off_ack) begin
        hold_off_ack    <= hold_off_req;
        hold_off_cycles <= HOLD_OFF_CYCLES;
        result_stall    <= 1'b1;
      end else if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        result_stall    <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        hold_off_cycles > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // valid stays up after a transfer; drain() or an idle gap before the next item lowers it
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_epsilon(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.eps = v;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      default: v = 32'($signed($urandom_range(400)) - 200);
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_half(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($urandom_range(8 << 16));
      default: return 31'($urandom_range(300));
    endcase
  endfunction

  // mostly nearby boxes so hits are common; some far-flung noise
  function automatic item_t rand_item();
    item_t it;
    int    m;
    m = $urandom_range(9);
    m = (m == 0) ? 0 : (m < 8 ? 1 : 2);
    it.a_center_x = rand_coord(m);
    it.a_center_y = rand_coord(m);
    it.b_center_x = rand_coord(m);
    it.b_center_y = rand_coord(m);
    it.a_half_x   = rand_half(m);
    it.a_half_y   = rand_half(m);
    it.b_half_x   = rand_half(m);
    it.b_half_y   = rand_half(m);
    it.a_angle    = $urandom;
    it.b_angle    = ($urandom_range(3) == 0) ? 16'($urandom_range(3) << 14) : 16'($urandom);
    return it;
  endfunction

  function automatic item_t mk(int acx, int acy, int ahx, int ahy, int aang,
                               int bcx, int bcy, int bhx, int bhy, int bang);
    item_t it;
    it.a_center_x = acx; it.a_center_y = acy;
    it.a_half_x = 31'(ahx); it.a_half_y = 31'(ahy); it.a_angle = 16'(aang);
    it.b_center_x = bcx; it.b_center_y = bcy;
    it.b_half_x = 31'(bhx); it.b_half_y = 31'(bhy); it.b_angle = 16'(bang);
    return it;
  endfunction

  task automatic directed();
    item_t it;
    send_item(mk(0, 0, 65536, 65536, 0, 65536, 0, 65536, 65536, 0));
    send_item(mk(0, 0, 65536, 65536, 0, -65536, 0, 65536, 65536, 0));
    send_item(mk(0, 0, 65536, 65536, 0, 0, 0, 65536, 65536, 0));        // zero distance
    send_item(mk(0, 0, 65536, 65536, 0, 0, 65536, 65536, 65536, 0));     // y overlap, A/B axes tie
    send_item(mk(0, 0, 65536, 65536, 0, 300000, 0, 65536, 65536, 0));   // separated
    send_item(mk(0, 0, 65536, 65536, 0, 131072, 0, 65536, 65536, 0));   // touching
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));                         // degenerate
    send_item(mk(0, 0, 0, 0, 0, 10, 10, 65536, 65536, 8192));
    send_item(mk(100, -100, 65536, 32768, 16384, 0, 0, 65536, 65536, 32768));
    send_item(mk(100, -100, 65536, 32768, 49152, 0, 0, 65536, 65536, 65535));
    send_item(mk(0, 0, 65536, 65536, 8192, 70000, 70000, 65536, 65536, 24576));
    send_item(mk(0, 0, 1, 1, 0, 0, 0, 1, 1, 0));                         // tiny depth
    it = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    it.a_half_x = '1; it.a_half_y = '1; it.b_half_x = '1; it.b_half_y = '1;
    send_item(it);                                                       // maximum half extents
    it.a_center_x = 32'h7FFF_FFFF; it.a_center_y = 32'h7FFF_FFFF;
    it.b_center_x = 32'h7FFF_FFFF; it.b_center_y = 32'h7FFF_FFFF;
    it.a_angle = 16'hFFFF; it.b_angle = 16'hFFFF;
    send_item(it);
    it.a_center_x = 32'h8000_0000; it.a_center_y = 32'h8000_0000;
    it.b_center_x = 32'h8000_0000; it.b_center_y = 32'h8000_0000;
    it.a_angle = 16'h4000; it.b_angle = 16'hC000;
    send_item(it);
    it.b_center_x = 32'h7FFF_FFFF; it.b_center_y = 32'h7FFF_FFFF;
    send_item(it);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    rst = 1'b1; item_valid = 1'b0; item = '0; cfg_valid = 1'b0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_req = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    drain();
    write_epsilon(16'd0);
    directed();
    random_phase(80, 0, 0);
    drain();
    write_epsilon(16'hFFFF);
    directed();
    random_phase(80, 46, 0);
    drain();
    write_epsilon(16'd300);
    random_phase(80, 0, 46);
    // long receiver hold-off while the sender keeps pushing
    hold_off_req = hold_off_req + 1;
    random_phase(40, 0, 0);
    drain();
    write_epsilon(16'd7);
    random_phase(120, 28, 28);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule

### sim.f
rtl/bbsc_pkg.sv
rtl/bbsc_sincos.sv
rtl/bbsc_proj.sv
rtl/bbsc_select.sv
rtl/bbsc_contact.sv
rtl/box_box_sat_contact_unit.sv
sim/tb.sv
